// ===== rtl/core/cht_pkg.sv =====
// Shared types and constants for the chained hash table.
// No dependencies.
package cht_pkg;
	localparam int MaxBuckets = 16;
	localparam int PoolNodes  = 64;
	localparam int NodeW      = $clog2(PoolNodes + 1);
	localparam int IdxW       = $clog2(PoolNodes);
	localparam int BktW       = $clog2(MaxBuckets);
	localparam int KeyW       = 31;
	localparam int ValW       = 32;
	localparam int CntW       = 7;
	localparam int CfgW       = 5;
	localparam int ModBits    = KeyW + 1;
	localparam int MsW        = $clog2(ModBits + 1);
	localparam logic [NodeW-1:0] NilNode = NodeW'(PoolNodes);

	localparam logic [1:0] CmdPut = 2'd0;
	localparam logic [1:0] CmdGet = 2'd1;
	localparam logic [1:0] CmdDel = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MOD, ST_HEAD, ST_RD, ST_CMP, ST_FREE, ST_ACT, ST_OUT
	} cht_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request word
		logic mod_step;  // one bit of the remainder
		logic head_load; // cur <= head of bucket
		logic rd_issue;  // read node at cur
		logic advance;   // prev <= cur, cur <= next
		logic free_step; // test one pool slot
		logic commit;    // apply the update
		logic out_load;  // capture the result word
	} cht_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mod_done;
		logic cur_nil;
		logic key_hit;
		logic walk_limit;
		logic free_done;
	} cht_stat_t;
endpackage

// ===== rtl/core/chained_hash_table.sv =====
// Top level of the chained hash table: controller plus datapath.
// Depends on cht_pkg, cht_ctrl, cht_dp.
//
//  channel  dir  handshake            payload
//  request  in   in_valid/in_stall    cmd, key, value
//  result   out  out_valid/out_stall  found, read_value, status, entry_count, is_empty
//  config   in   cfg_we               cfg_wdata (bucket_count)
//
// One request at a time: a bit-serial remainder over the key bits, a read
// state and a compare state per chain node, a free-slot scan on a new put,
// plus the states for request capture, head load and the final commit.
// Reset clears the heads, pool flags and count at once; no clearing pass.
// A held result word stalls only the final commit, not request acceptance.
module chained_hash_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cht_pkg::CfgW-1:0]           cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         cmd,
	input  logic [cht_pkg::KeyW-1:0]           key,
	input  logic [cht_pkg::ValW-1:0]           value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               found,
	output logic [cht_pkg::ValW-1:0]           read_value,
	output logic                               status,
	output logic [cht_pkg::CntW-1:0]           entry_count,
	output logic                               is_empty
);
	cht_pkg::cht_cmd_t  cm;
	cht_pkg::cht_stat_t st;
	logic [1:0]         cmd_q;

	cht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd_q(cmd_q), .st(st), .cm(cm)
	);

	cht_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.cmd(cmd), .key(key), .value(value), .cm(cm), .st(st), .cmd_q(cmd_q),
		.found(found), .read_value(read_value), .status(status),
		.entry_count(entry_count), .is_empty(is_empty)
	);
endmodule

// ===== rtl/core/cht_ctrl.sv =====
// Sequencer for one request: remainder, chain walk, free search, update.
// Depends on cht_pkg.
module cht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  logic [1:0]          cmd_q,
	input  cht_pkg::cht_stat_t  st,
	output cht_pkg::cht_cmd_t   cm
);
	cht_pkg::cht_state_t state_q, state_d;
	logic out_valid_q, out_valid_d;
	logic busy;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cht_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign busy      = (state_q != cht_pkg::ST_IDLE);
	assign in_stall  = busy;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cm          = '0;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			cht_pkg::ST_IDLE: begin
				if (in_valid) begin
					cm.load = 1'b1;
					state_d = cht_pkg::ST_MOD;
				end
			end
			cht_pkg::ST_MOD: begin
				cm.mod_step = 1'b1;
				if (st.mod_done) state_d = cht_pkg::ST_HEAD;
			end
			cht_pkg::ST_HEAD: begin
				cm.head_load = 1'b1;
				state_d = cht_pkg::ST_RD;
			end
			cht_pkg::ST_RD: begin
				if (st.cur_nil || st.walk_limit || cmd_q > cht_pkg::CmdDel) begin
					state_d = cht_pkg::ST_FREE;
				end else begin
					cm.rd_issue = 1'b1;
					state_d = cht_pkg::ST_CMP;
				end
			end
			cht_pkg::ST_CMP: begin
				if (st.key_hit) begin
					state_d = cht_pkg::ST_ACT;
				end else begin
					cm.advance = 1'b1;
					state_d = cht_pkg::ST_RD;
				end
			end
			cht_pkg::ST_FREE: begin
				// free search matters only for a new put
				cm.free_step = 1'b1;
				if (st.free_done || cmd_q != cht_pkg::CmdPut) state_d = cht_pkg::ST_ACT;
			end
			cht_pkg::ST_ACT: begin
				if (!out_valid_q || !out_stall) begin
					cm.commit   = 1'b1;
					cm.out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d     = cht_pkg::ST_IDLE;
				end
			end
			default: state_d = cht_pkg::ST_IDLE;
		endcase
	end

	// a new word never overwrites one still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result word lost");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cm.load |-> (state_q == cht_pkg::ST_IDLE))
		else $error("load while busy");
	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cm.commit |=> !cm.commit)
		else $error("double commit");
endmodule

// ===== rtl/core/cht_dp.sv =====
// Datapath: bit-serial remainder, node memories, pool flags, counters.
// Depends on cht_pkg.
module cht_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cht_pkg::CfgW-1:0]     cfg_wdata,
	input  logic [1:0]                   cmd,
	input  logic [cht_pkg::KeyW-1:0]     key,
	input  logic [cht_pkg::ValW-1:0]     value,
	input  cht_pkg::cht_cmd_t            cm,
	output cht_pkg::cht_stat_t           st,
	output logic [1:0]                   cmd_q,
	output logic                         found,
	output logic [cht_pkg::ValW-1:0]     read_value,
	output logic                         status,
	output logic [cht_pkg::CntW-1:0]     entry_count,
	output logic                         is_empty
);
	logic [cht_pkg::CfgW-1:0]    bcount_q;
	logic [cht_pkg::KeyW-1:0]    key_q;
	logic [cht_pkg::ValW-1:0]    val_q;
	logic [cht_pkg::KeyW-1:0]    shift_q;
	logic [cht_pkg::CfgW:0]      rem_q;
	logic [cht_pkg::MsW-1:0]     mstep_q;
	logic [cht_pkg::CfgW-1:0]    div;
	logic [cht_pkg::CfgW:0]      rem_sh;

	logic [cht_pkg::NodeW-1:0]   heads_q [cht_pkg::MaxBuckets];
	logic [cht_pkg::KeyW-1:0]    mkey  [cht_pkg::PoolNodes];
	logic [cht_pkg::ValW-1:0]    mval  [cht_pkg::PoolNodes];
	logic [cht_pkg::NodeW-1:0]   mnext [cht_pkg::PoolNodes];
	logic [cht_pkg::PoolNodes-1:0] used_q;

	logic [cht_pkg::KeyW-1:0]    rkey_q;
	logic [cht_pkg::ValW-1:0]    rval_q;
	logic [cht_pkg::NodeW-1:0]   rnext_q;
	logic [cht_pkg::NodeW-1:0]   cur_q, prev_q, tail_q;
	logic [cht_pkg::NodeW-1:0]   steps_q;
	logic                        hit_q;
	logic [cht_pkg::NodeW-1:0]   fscan_q, free_q;
	logic [cht_pkg::CntW-1:0]    count_q;
	logic [cht_pkg::BktW-1:0]    bkt;
	logic [cht_pkg::IdxW-1:0]    cur_i, prev_i, tail_i, free_i;
	logic                        new_put;

	// register and effective divisor (zero as one, saturate at the bucket limit)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bcount_q <= cht_pkg::CfgW'(10);
		else if (cfg_we) bcount_q <= cfg_wdata;
	end
	always_comb begin
		if (bcount_q == '0) div = cht_pkg::CfgW'(1);
		else if (bcount_q > cht_pkg::CfgW'(cht_pkg::MaxBuckets))
			div = cht_pkg::CfgW'(cht_pkg::MaxBuckets);
		else div = bcount_q;
	end

	// restoring remainder, one key bit a cycle
	assign rem_sh = {rem_q[cht_pkg::CfgW-1:0], shift_q[cht_pkg::KeyW-1]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstep_q <= '0;
			cmd_q   <= '0;
		end else if (cm.load) begin
			mstep_q <= '0;
			cmd_q   <= cmd;
		end else if (cm.mod_step) begin
			mstep_q <= mstep_q + cht_pkg::MsW'(1);
		end
	end
	always_ff @(posedge clk) begin
		if (cm.load) begin
			key_q   <= key;
			val_q   <= value;
			shift_q <= key;
			rem_q   <= '0;
		end else if (cm.mod_step) begin
			shift_q <= {shift_q[cht_pkg::KeyW-2:0], 1'b0};
			rem_q   <= (rem_sh >= {1'b0, div}) ? rem_sh - {1'b0, div} : rem_sh;
		end
	end
	assign st.mod_done = (mstep_q == cht_pkg::MsW'(cht_pkg::KeyW - 1)) && cm.mod_step;
	assign bkt = rem_q[cht_pkg::BktW-1:0];

	assign cur_i  = cur_q[cht_pkg::IdxW-1:0];
	assign prev_i = prev_q[cht_pkg::IdxW-1:0];
	assign tail_i = tail_q[cht_pkg::IdxW-1:0];
	assign free_i = free_q[cht_pkg::IdxW-1:0];

	// node memory reads, registered
	always_ff @(posedge clk) begin
		if (cm.rd_issue) begin
			rkey_q  <= mkey[cur_i];
			rval_q  <= mval[cur_i];
			rnext_q <= mnext[cur_i];
		end
	end
	assign st.key_hit    = (rkey_q == key_q);
	assign st.cur_nil    = (cur_q >= cht_pkg::NilNode);
	assign st.walk_limit = (steps_q >= cht_pkg::NodeW'(cht_pkg::PoolNodes));

	// chain walk pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= cht_pkg::NilNode;
			prev_q  <= cht_pkg::NilNode;
			tail_q  <= cht_pkg::NilNode;
			steps_q <= '0;
			hit_q   <= 1'b0;
		end else if (cm.head_load) begin
			cur_q   <= heads_q[bkt];
			prev_q  <= cht_pkg::NilNode;
			tail_q  <= cht_pkg::NilNode;
			steps_q <= '0;
			hit_q   <= 1'b0;
		end else if (cm.rd_issue) begin
			tail_q  <= cur_q;
			steps_q <= steps_q + cht_pkg::NodeW'(1);
		end else if (cm.advance) begin
			prev_q <= cur_q;
			cur_q  <= rnext_q;
		end else if (st.key_hit && !hit_q && !cm.free_step && !cm.commit &&
				!cm.load && !cm.mod_step && cur_q < cht_pkg::NilNode && steps_q != '0 &&
				tail_q == cur_q) begin
			hit_q <= 1'b1;
		end
	end

	// lowest free slot, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fscan_q <= '0;
			free_q  <= cht_pkg::NilNode;
		end else if (cm.head_load) begin
			fscan_q <= '0;
			free_q  <= cht_pkg::NilNode;
		end else if (cm.free_step && !st.free_done) begin
			if (!used_q[fscan_q[cht_pkg::IdxW-1:0]]) free_q <= fscan_q;
			else fscan_q <= fscan_q + cht_pkg::NodeW'(1);
		end
	end
	assign st.free_done = (free_q != cht_pkg::NilNode) ||
		(fscan_q >= cht_pkg::NodeW'(cht_pkg::PoolNodes));

	assign new_put = (cmd_q == cht_pkg::CmdPut) && !hit_q;

	// update of memories, heads, flags and count
	always_ff @(posedge clk) begin
		if (cm.commit) begin
			if (cmd_q == cht_pkg::CmdPut && hit_q) begin
				mval[cur_i] <= val_q;
			end else if (new_put && free_q != cht_pkg::NilNode) begin
				mkey[free_i]  <= key_q;
				mval[free_i]  <= val_q;
				mnext[free_i] <= cht_pkg::NilNode;
				if (tail_q != cht_pkg::NilNode) mnext[tail_i] <= free_q;
			end else if (cmd_q == cht_pkg::CmdDel && hit_q) begin
				if (prev_q != cht_pkg::NilNode) mnext[prev_i] <= rnext_q;
				mnext[cur_i] <= cht_pkg::NilNode;
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cht_pkg::MaxBuckets; i++) heads_q[i] <= cht_pkg::NilNode;
			used_q  <= '0;
			count_q <= '0;
		end else if (cm.commit) begin
			if (new_put && free_q != cht_pkg::NilNode) begin
				used_q[free_i] <= 1'b1;
				count_q <= count_q + cht_pkg::CntW'(1);
				if (tail_q == cht_pkg::NilNode) heads_q[bkt] <= free_q;
			end else if (cmd_q == cht_pkg::CmdDel && hit_q) begin
				used_q[cur_i] <= 1'b0;
				if (prev_q == cht_pkg::NilNode) heads_q[bkt] <= rnext_q;
				if (count_q != '0) count_q <= count_q - cht_pkg::CntW'(1);
			end
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found       <= 1'b0;
			read_value  <= '0;
			status      <= 1'b0;
			entry_count <= '0;
			is_empty    <= 1'b1;
		end else if (cm.out_load) begin
			found      <= hit_q;
			read_value <= (cmd_q == cht_pkg::CmdGet && hit_q) ? rval_q : '0;
			status     <= new_put && free_q == cht_pkg::NilNode;
			if (new_put && free_q != cht_pkg::NilNode) begin
				entry_count <= count_q + cht_pkg::CntW'(1);
				is_empty    <= 1'b0;
			end else if (cmd_q == cht_pkg::CmdDel && hit_q && count_q != '0) begin
				entry_count <= count_q - cht_pkg::CntW'(1);
				is_empty    <= (count_q == cht_pkg::CntW'(1));
			end else begin
				entry_count <= count_q;
				is_empty    <= (count_q == '0);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cht_pkg::CntW'(cht_pkg::PoolNodes))
		else $error("count beyond pool");
	a_count_flags: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(count_q))
		else $error("count and pool flags disagree");
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cm.commit && new_put && free_q != cht_pkg::NilNode) |-> !used_q[free_i])
		else $error("allocating a used node");
endmodule
